// ===== hw/rtl/obj_text_number_parser_assert.svh =====
// Assertion macros used by the parser checker.
`ifndef OBJ_TEXT_NUMBER_PARSER_ASSERT_SVH
`define OBJ_TEXT_NUMBER_PARSER_ASSERT_SVH

// Same-cycle implication.
`define ONTP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ontp assertion failed");

// Next-cycle implication.
`define ONTP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ontp assertion failed");

`endif

// ===== hw/rtl/ontp_pkg.sv =====
`default_nettype none

package ontp_pkg;

   localparam int INT_DIGITS  = 9;
   localparam int FRAC_DIGITS = 6;
   localparam int MAX_FIELDS  = 16;

   // Payload widths
   localparam int BYTE_W   = 8;
   localparam int VALUE_W  = 51;
   localparam int ACC_W    = VALUE_W - 1;
   localparam int EXT_W    = ACC_W + 4;
   localparam int POS_W    = 4;
   localparam int SLOT_W   = 2;
   localparam int CNT_W    = 3;
   localparam int FC_W     = $clog2(MAX_FIELDS + 1);
   localparam int FCX_W    = (FC_W > POS_W) ? FC_W : POS_W;
   localparam int KW_W     = 16;
   localparam int RSP_DATA_W = ((POS_W + VALUE_W + 7) / 8) * 8;
   localparam int RSP_USER_W = 6;

   // Bit positions inside rsp_tuser / rsp_tdata
   localparam int USER_KIND_LO  = 0;
   localparam int USER_SLOT_LO  = 2;
   localparam int USER_PRESENT  = 4;
   localparam int USER_ERROR    = 5;
   localparam int DATA_VALUE_LO = POS_W;

   typedef enum logic [1:0] {
      KIND_VERTEX  = 2'd0,
      KIND_TEXTURE = 2'd1,
      KIND_NORMAL  = 2'd2,
      KIND_FACE    = 2'd3
   } kind_type;

   localparam logic [SLOT_W-1:0] SLOT_LAST = 2'd2;

   // Characters
   localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_HASH  = 8'h23;
   localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2F;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

   // Keywords as shifted-in characters
   localparam logic [KW_W-1:0] KW_V  = 16'h0076;
   localparam logic [KW_W-1:0] KW_VT = 16'h7674;
   localparam logic [KW_W-1:0] KW_VN = 16'h766E;
   localparam logic [KW_W-1:0] KW_F  = 16'h0066;

   typedef struct packed {
      logic neg;
      logic dot;
      logic dig;
      logic bad;
      logic sat;
   } num_flags_type;

   typedef struct packed {
      logic                    eol;
      logic                    error;
      logic                    present;
      logic signed [VALUE_W-1:0] value;
      logic [SLOT_W-1:0]       slot;
      logic [POS_W-1:0]        pos;
      kind_type                kind;
   } result_type;

   typedef logic [ACC_W-1:0] pow_tab_type [2**CNT_W];

   function automatic longint unsigned pow10(input int n);
      longint unsigned r;
      r = 1;
      for (int i = 0; i < n; i++) begin
         r = r * 10;
      end
      return r;
   endfunction

   // 10^k for k up to FRAC_DIGITS, zero above
   function automatic pow_tab_type build_pow_tab();
      pow_tab_type t;
      for (int k = 0; k < 2**CNT_W; k++) begin
         t[k] = (k <= FRAC_DIGITS) ? ACC_W'(pow10(k)) : '0;
      end
      return t;
   endfunction

   localparam pow_tab_type POW_TAB = build_pow_tab();
   localparam logic [ACC_W-1:0] VALUE_LIMIT = ACC_W'(pow10(INT_DIGITS + FRAC_DIGITS) - 1);
   localparam logic [CNT_W-1:0] FRAC_LAST = CNT_W'(FRAC_DIGITS - 1);

endpackage

`default_nettype wire

// ===== hw/rtl/obj_text_number_parser.sv =====
// obj_text_number_parser: OBJ text to number stream.
// Input channel (req_*): one text byte per request in req_tdata[7:0]. A zero
// byte ends the text; every byte after it is dropped until reset.
// Result channel (rsp_*): one request per number found on v, vt, vn and f
// lines. rsp_tdata carries the field position and the signed value (vertex
// numbers scaled by 10^6, face indices as integers); rsp_tuser carries kind,
// face slot, digits-present and error flags; rsp_tlast marks the last result
// of a line. Lines with any other keyword and comments give no results.
// Path: a byte is held in the input register and parsed into the result
// register; its result, if it has one, stays on rsp_* until taken.
// Throughput: one byte per cycle while the receiver does not stall; the
// parse of a byte is one pass through the digit multiply-add and limit
// compare between the input and result registers.
// Reset (synchronous, active high) returns to the start of a line and empties
// both registers. When the receiver stalls, the result register holds its
// request, the held byte waits, and req_tready drops while both are full; no
// result is lost or repeated.
`default_nettype none

module obj_text_number_parser (
   input  logic        clock,
   input  logic        reset,
   // request side
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   // result side
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [3:0] field_position, [54:4] number_value, [55] zero
   output logic [5:0]  rsp_tuser,   // [1:0] record_kind, [3:2] slot_index,
                                    // [4] field_present, [5] value_error
   output logic        rsp_tlast    // end_of_line
);

   typedef enum logic [2:0] {
      MODE_START,
      MODE_SKIP,
      MODE_GAP,
      MODE_NUM,
      MODE_DONE,
      MODE_GAPC,
      MODE_NUMC
   } mode_type;

   // input register
   logic                           in_valid_ff, in_valid_in;
   logic [ontp_pkg::BYTE_W-1:0]    in_byte_ff, in_byte_in;

   // parse state
   mode_type                       mode_ff, mode_in;
   logic [ontp_pkg::KW_W-1:0]      keyword_ff, keyword_in;
   logic [ontp_pkg::FC_W-1:0]      field_ff, field_in;
   logic [ontp_pkg::SLOT_W-1:0]    slot_ff, slot_in;
   logic [ontp_pkg::ACC_W-1:0]     acc_ff, acc_in;
   logic [ontp_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   ontp_pkg::num_flags_type        flags_ff, flags_in;

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   ontp_pkg::result_type           rsp_ff, rsp_in;

   // step control
   logic advance;
   logic step;

   // decode of the held byte
   logic [ontp_pkg::BYTE_W-1:0] c;
   logic is_sep, is_eol, is_digit, is_hash;
   logic [3:0] digit;
   logic kind_ok, face;
   ontp_pkg::kind_type kind;

   // number state as seen by the current byte (cleared when a number opens)
   logic [ontp_pkg::SLOT_W-1:0] b_slot;
   logic [ontp_pkg::ACC_W-1:0]  b_acc;
   logic [ontp_pkg::CNT_W-1:0]  b_cnt;
   ontp_pkg::num_flags_type     b_flags;

   // digit accumulate
   logic                        frac_digit, take_digit;
   logic [ontp_pkg::CNT_W-1:0]  frac_idx;
   logic [ontp_pkg::ACC_W-1:0]  scale;
   logic [ontp_pkg::EXT_W-1:0]  acc_base, term, sum;
   logic                        over;

   // field result built from the number state
   logic                        room;
   logic [ontp_pkg::FCX_W-1:0]  field_x;
   logic [ontp_pkg::POS_W-1:0]  pos;
   logic signed [ontp_pkg::VALUE_W-1:0] mag_s;
   ontp_pkg::result_type        field_res, marker_res;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   assign c        = in_byte_ff;
   assign is_sep   = (c == ontp_pkg::CHAR_SPACE) || (c == ontp_pkg::CHAR_TAB) ||
                     (c == ontp_pkg::CHAR_CR);
   assign is_eol   = (c == ontp_pkg::CHAR_NUL) || (c == ontp_pkg::CHAR_LF);
   assign is_hash  = (c == ontp_pkg::CHAR_HASH);
   assign is_digit = (c >= ontp_pkg::CHAR_ZERO) && (c <= ontp_pkg::CHAR_NINE);
   assign digit    = 4'(c - ontp_pkg::CHAR_ZERO);

   // keyword to record kind
   always_comb begin
      kind_ok = 1'b1;
      kind    = ontp_pkg::KIND_VERTEX;
      priority if (keyword_ff == ontp_pkg::KW_V) begin
         kind = ontp_pkg::KIND_VERTEX;
      end else if (keyword_ff == ontp_pkg::KW_VT) begin
         kind = ontp_pkg::KIND_TEXTURE;
      end else if (keyword_ff == ontp_pkg::KW_VN) begin
         kind = ontp_pkg::KIND_NORMAL;
      end else if (keyword_ff == ontp_pkg::KW_F) begin
         kind = ontp_pkg::KIND_FACE;
      end else begin
         kind_ok = 1'b0;
      end
   end
   assign face = kind_ok && (kind == ontp_pkg::KIND_FACE);

   // a byte arriving in the gap opens a fresh number
   always_comb begin
      if (mode_ff == MODE_GAP) begin
         b_slot  = '0;
         b_acc   = '0;
         b_cnt   = '0;
         b_flags = '0;
      end else begin
         b_slot  = slot_ff;
         b_acc   = acc_ff;
         b_cnt   = cnt_ff;
         b_flags = flags_ff;
      end
   end

   // Vertex values accumulate already scaled: integer digits add d*10^F to
   // acc*10, fraction digits add d*10^(F-1-count). Faces add d to acc*10.
   // Any overshoot of the limit pins the accumulator and sets saturation.
   assign frac_digit = !face && b_flags.dot;
   assign take_digit = !frac_digit || (32'(b_cnt) < ontp_pkg::FRAC_DIGITS);
   assign frac_idx   = ontp_pkg::FRAC_LAST - b_cnt;

   always_comb begin
      if (face) begin
         scale = ontp_pkg::ACC_W'(1);
      end else if (frac_digit) begin
         scale = ontp_pkg::POW_TAB[frac_idx];
      end else begin
         scale = ontp_pkg::POW_TAB[ontp_pkg::FRAC_DIGITS];
      end
   end

   assign acc_base = frac_digit ? ontp_pkg::EXT_W'(b_acc) :
                     (ontp_pkg::EXT_W'(b_acc) << 3) + (ontp_pkg::EXT_W'(b_acc) << 1);
   assign term     = ontp_pkg::EXT_W'(digit) * ontp_pkg::EXT_W'(scale);
   assign sum      = acc_base + term;
   assign over     = sum > ontp_pkg::EXT_W'(ontp_pkg::VALUE_LIMIT);

   // result for the open number
   assign room    = 32'(field_ff) < ontp_pkg::MAX_FIELDS;
   assign field_x = ontp_pkg::FCX_W'(field_ff);
   assign pos     = (field_x > ontp_pkg::FCX_W'(15)) ? 4'hF : field_x[ontp_pkg::POS_W-1:0];
   assign mag_s   = ontp_pkg::VALUE_W'(b_acc);

   always_comb begin
      field_res.kind    = kind;
      field_res.pos     = pos;
      field_res.slot    = face ? b_slot : '0;
      field_res.value   = b_flags.bad ? '0 : (b_flags.neg ? -mag_s : mag_s);
      field_res.present = b_flags.dig;
      field_res.error   = b_flags.bad || b_flags.sat;
      field_res.eol     = 1'b0;

      marker_res         = '0;
      marker_res.kind    = kind;
      marker_res.pos     = pos;
      marker_res.eol     = 1'b1;
   end

   // one byte of parsing
   always_comb begin
      mode_in    = mode_ff;
      keyword_in = keyword_ff;
      field_in   = field_ff;
      slot_in    = slot_ff;
      acc_in     = acc_ff;
      cnt_in     = cnt_ff;
      flags_in   = flags_ff;
      rsp_in     = rsp_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;

      if (step && (mode_ff != MODE_DONE)) begin
         if (is_eol) begin
            // close the open number and the line
            unique case (mode_ff)
               MODE_START: begin
                  if (kind_ok) begin
                     rsp_in       = marker_res;
                     rsp_valid_in = 1'b1;
                  end
               end
               MODE_GAP, MODE_GAPC: begin
                  rsp_in       = marker_res;
                  rsp_valid_in = 1'b1;
               end
               MODE_NUM, MODE_NUMC: begin
                  rsp_in       = room ? field_res : marker_res;
                  rsp_in.eol   = 1'b1;
                  rsp_valid_in = 1'b1;
               end
               default: begin
               end
            endcase
            mode_in    = (c == ontp_pkg::CHAR_NUL) ? MODE_DONE : MODE_START;
            keyword_in = '0;
            field_in   = '0;
            slot_in    = '0;
            acc_in     = '0;
            cnt_in     = '0;
            flags_in   = '0;
         end else begin
            unique case (mode_ff)
               MODE_START: begin
                  if (is_hash) begin
                     mode_in = kind_ok ? MODE_GAPC : MODE_SKIP;
                  end else if (is_sep) begin
                     if (keyword_ff != '0) begin
                        mode_in = kind_ok ? MODE_GAP : MODE_SKIP;
                     end
                  end else if (keyword_ff[ontp_pkg::KW_W-1:8] != '0) begin
                     mode_in = MODE_SKIP;
                  end else begin
                     keyword_in = {keyword_ff[7:0], c};
                  end
               end
               MODE_GAP, MODE_NUM: begin
                  if (is_hash) begin
                     mode_in = (mode_ff == MODE_GAP) ? MODE_GAPC : MODE_NUMC;
                  end else if (is_sep) begin
                     if (mode_ff == MODE_NUM) begin
                        // field done: emit, advance position, wait for next
                        if (room) begin
                           rsp_in       = field_res;
                           rsp_valid_in = 1'b1;
                           field_in     = field_ff + 1'b1;
                        end
                        slot_in  = '0;
                        acc_in   = '0;
                        cnt_in   = '0;
                        flags_in = '0;
                        mode_in  = MODE_GAP;
                     end
                  end else begin
                     mode_in  = MODE_NUM;
                     slot_in  = b_slot;
                     acc_in   = b_acc;
                     cnt_in   = b_cnt;
                     flags_in = b_flags;
                     priority if (face && (c == ontp_pkg::CHAR_SLASH)) begin
                        if (b_slot >= ontp_pkg::SLOT_LAST) begin
                           flags_in.bad = 1'b1;
                        end else begin
                           if (room) begin
                              rsp_in       = field_res;
                              rsp_valid_in = 1'b1;
                           end
                           slot_in  = b_slot + 1'b1;
                           acc_in   = '0;
                           cnt_in   = '0;
                           flags_in = '0;
                        end
                     end else if (is_digit) begin
                        flags_in.dig = 1'b1;
                        if (take_digit) begin
                           if (over) begin
                              acc_in       = ontp_pkg::VALUE_LIMIT;
                              flags_in.sat = 1'b1;
                           end else begin
                              acc_in = sum[ontp_pkg::ACC_W-1:0];
                           end
                           if (frac_digit) begin
                              cnt_in = b_cnt + 1'b1;
                           end
                        end
                     end else if (c == ontp_pkg::CHAR_MINUS) begin
                        if (b_flags.dig || b_flags.dot || b_flags.neg) begin
                           flags_in.bad = 1'b1;
                        end else begin
                           flags_in.neg = 1'b1;
                        end
                     end else if (c == ontp_pkg::CHAR_PLUS) begin
                        if (b_flags.dig || b_flags.dot) begin
                           flags_in.bad = 1'b1;
                        end
                     end else if ((c == ontp_pkg::CHAR_DOT) && !face && !b_flags.dot) begin
                        flags_in.dot = 1'b1;
                     end else begin
                        flags_in.bad = 1'b1;
                     end
                  end
               end
               default: begin
                  // skipped line, comment tail: drop the byte
               end
            endcase
         end
      end
   end

   // input register: take a byte when it is empty or the held one moves on
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_START;
         keyword_ff   <= '0;
         field_ff     <= '0;
         slot_ff      <= '0;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         flags_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         keyword_ff   <= keyword_in;
         field_ff     <= field_in;
         slot_ff      <= slot_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         flags_ff     <= flags_in;
      end
      in_byte_ff <= in_byte_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.value, rsp_ff.pos};
   assign rsp_tuser  = {rsp_ff.error, rsp_ff.present, rsp_ff.slot, rsp_ff.kind};
   assign rsp_tlast  = rsp_ff.eol;

endmodule

`default_nettype wire

// ===== hw/rtl/ontp_checker.sv =====
`default_nettype none

`include "obj_text_number_parser_assert.svh"

module ontp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [5:0]  rsp_tuser,
   input logic        rsp_tlast
);

   logic [ontp_pkg::SLOT_W-1:0]  slot;
   logic [1:0]                   kind;
   logic [ontp_pkg::VALUE_W-1:0] value;

   assign slot  = rsp_tuser[ontp_pkg::USER_SLOT_LO +: ontp_pkg::SLOT_W];
   assign kind  = rsp_tuser[ontp_pkg::USER_KIND_LO +: 2];
   assign value = rsp_tdata[ontp_pkg::DATA_VALUE_LO +: ontp_pkg::VALUE_W];

   // stalled result holds
   `ONTP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // a draining result side never blocks the request side
   `ONTP_ASSERT_IMP(a_ready_flow, clock, reset, rsp_tready, req_tready)

   // no digits and no error means a zero value
   `ONTP_ASSERT_IMP(a_empty_zero, clock, reset, rsp_tvalid && !rsp_tuser[ontp_pkg::USER_PRESENT] && !rsp_tuser[ontp_pkg::USER_ERROR], value == '0)

   // slots only on face lines, never past the normal slot
   `ONTP_ASSERT_IMP(a_slot_range, clock, reset, rsp_tvalid, (slot <= ontp_pkg::SLOT_LAST) && ((kind == ontp_pkg::KIND_FACE) || (slot == '0)))

endmodule

bind obj_text_number_parser ontp_checker u_ontp_checker (.*);

`default_nettype wire
